FILE: rtl/cmca_pkg.sv
// Package for the complex matrix commutator accumulator.
// Holds shared constants, register and mode codes, the config struct and the back-end state type.
// No dependencies.
package cmca_pkg;

	localparam int MAX_ORDER_DEF  = 8;
	localparam int DATA_WIDTH_DEF = 32;
	localparam int FRAC_BITS      = 24;
	localparam int QUEUE_DEPTH    = 4;
	localparam int CFG_IDX_W      = 2;
	localparam int CFG_DATA_W     = 32;

	localparam logic [CFG_IDX_W-1:0] REG_MODE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COEF  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ORDER = 2'd2;

	localparam logic [1:0] MODE_FULL = 2'd0;
	localparam logic [1:0] MODE_ANTI = 2'd1;
	localparam logic [1:0] MODE_HERM = 2'd2;

	localparam logic [31:0] COEF_RESET  = 32'd16777216;
	localparam logic [3:0]  ORDER_RESET = 4'd8;

	typedef struct packed {
		logic [1:0]  mode;
		logic [3:0]  order;
		logic [31:0] coef;
	} cfg_t;

	typedef enum logic [2:0] {
		BK_LOAD,
		BK_ISSUE,
		BK_DRAIN,
		BK_SCALE,
		BK_WRITE,
		BK_EMIT
	} bk_state_t;

	function automatic int clamp_order(input logic [3:0] order, input int max_order);
		int r;
		r = int'(order);
		if (r < 1) r = 1;
		if (r > max_order) r = max_order;
		return r;
	endfunction

endpackage

FILE: rtl/cmca_if.sv
// Channel interfaces for the complex matrix commutator accumulator.
// Input item channel, result item channel and config write channel.
// Depends on cmca_pkg.
interface cmca_in_if #(parameter int DATA_WIDTH = cmca_pkg::DATA_WIDTH_DEF) ();
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] a_re;
	logic signed [DATA_WIDTH-1:0] a_im;
	logic signed [DATA_WIDTH-1:0] b_re;
	logic signed [DATA_WIDTH-1:0] b_im;
	logic signed [DATA_WIDTH-1:0] acc_re;
	logic signed [DATA_WIDTH-1:0] acc_im;
	modport source(output valid, a_re, a_im, b_re, b_im, acc_re, acc_im, input ready);
	modport sink(input valid, a_re, a_im, b_re, b_im, acc_re, acc_im, output ready);
endinterface

interface cmca_out_if #(parameter int DATA_WIDTH = cmca_pkg::DATA_WIDTH_DEF) ();
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] res_re;
	logic signed [DATA_WIDTH-1:0] res_im;
	logic                         last_element;
	modport source(output valid, res_re, res_im, last_element, input ready);
	modport sink(input valid, res_re, res_im, last_element, output ready);
endinterface

interface cmca_cfg_if ();
	logic                             valid;
	logic                             ready;
	logic [cmca_pkg::CFG_IDX_W-1:0]   index;
	logic [cmca_pkg::CFG_DATA_W-1:0]  data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

FILE: rtl/cmca_front.sv
// Front end: config registers, item acceptance and load counting.
// Tags each item with its store index and a matrix-complete flag for the queue.
// Depends on cmca_pkg.
module cmca_front #(
	parameter int MAX_ORDER  = cmca_pkg::MAX_ORDER_DEF,
	parameter int DATA_WIDTH = cmca_pkg::DATA_WIDTH_DEF,
	localparam int IW = $clog2(MAX_ORDER * MAX_ORDER),
	localparam int QW = 6 * DATA_WIDTH + IW + 1
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [cmca_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cmca_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [DATA_WIDTH-1:0]           a_re,
	input  logic [DATA_WIDTH-1:0]           a_im,
	input  logic [DATA_WIDTH-1:0]           b_re,
	input  logic [DATA_WIDTH-1:0]           b_im,
	input  logic [DATA_WIDTH-1:0]           acc_re,
	input  logic [DATA_WIDTH-1:0]           acc_im,
	output logic                            push_valid,
	input  logic                            push_ready,
	output logic [QW-1:0]                   push_data,
	output cmca_pkg::cfg_t                  cfg_o
);
	localparam int CW = IW + 1;
	localparam int NW = $clog2(MAX_ORDER + 1);

	cmca_pkg::cfg_t  cfg_q;
	logic [CW-1:0]   load_count_q;
	logic [NW-1:0]   n_w;
	logic [2*NW-1:0] total_w;
	logic            last_w;

	assign cfg_ready = 1'b1;
	assign cfg_o     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode  <= cmca_pkg::MODE_FULL;
			cfg_q.order <= cmca_pkg::ORDER_RESET;
			cfg_q.coef  <= cmca_pkg::COEF_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				cmca_pkg::REG_MODE:  cfg_q.mode  <= cfg_data[1:0];
				cmca_pkg::REG_COEF:  cfg_q.coef  <= cfg_data;
				cmca_pkg::REG_ORDER: cfg_q.order <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		n_w     = NW'(cmca_pkg::clamp_order(cfg_q.order, MAX_ORDER));
		total_w = {NW'(0), n_w} * {NW'(0), n_w};
		last_w  = (int'(load_count_q) + 1) >= int'(total_w);
	end

	assign in_ready   = push_ready;
	assign push_valid = in_valid;
	assign push_data  = {last_w, load_count_q[IW-1:0], a_re, a_im, b_re, b_im, acc_re, acc_im};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_count_q <= '0;
		end else if (in_valid && push_ready) begin
			load_count_q <= last_w ? '0 : load_count_q + CW'(1);
		end
	end

endmodule

FILE: rtl/cmca_queue.sv
// Short item queue between front and back end.
// Plain FIFO with valid/ready on both sides.
// No dependencies.
module cmca_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);
	localparam int AW = $clog2(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_q;
	logic [AW-1:0]    rd_q;
	logic [AW:0]      cnt_q;
	logic             push_w;
	logic             pop_w;

	assign push_ready = cnt_q != (AW+1)'(DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign pop_data   = mem_q[rd_q];
	assign push_w     = push_valid && push_ready;
	assign pop_w      = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push_w) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push_w) wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
			if (pop_w)  rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
			case ({push_w, pop_w})
				2'b10:   cnt_q <= cnt_q + (AW+1)'(1);
				2'b01:   cnt_q <= cnt_q - (AW+1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

FILE: rtl/cmca_back.sv
// Back end: matrix stores, shared complex MAC, scaling, saturation and result emission.
// Pops tagged items from the queue; a matrix-complete item starts the computation.
// Depends on cmca_pkg.
module cmca_back #(
	parameter int MAX_ORDER  = cmca_pkg::MAX_ORDER_DEF,
	parameter int DATA_WIDTH = cmca_pkg::DATA_WIDTH_DEF,
	localparam int IW = $clog2(MAX_ORDER * MAX_ORDER),
	localparam int QW = 6 * DATA_WIDTH + IW + 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  pop_valid,
	output logic                  pop_ready,
	input  logic [QW-1:0]         pop_data,
	input  cmca_pkg::cfg_t        cfg_i,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [DATA_WIDTH-1:0] res_re,
	output logic [DATA_WIDTH-1:0] res_im,
	output logic                  last_element
);
	localparam int DEPTH = MAX_ORDER * MAX_ORDER;
	localparam int DW    = DATA_WIDTH;
	localparam int PW    = 2 * DW;
	localparam int FRAC  = cmca_pkg::FRAC_BITS;
	localparam int FW    = PW - FRAC;
	localparam int NW    = $clog2(MAX_ORDER + 1);
	localparam int OW    = $clog2(MAX_ORDER);
	localparam int SW    = OW + 1;
	localparam int MW    = OW + NW;
	localparam int DDW0  = FW + $clog2(4 * MAX_ORDER) + 1;
	localparam int DDW   = (DDW0 > FRAC + 1) ? DDW0 : FRAC + 2;
	localparam int HW    = DDW - FRAC;
	localparam int KHW   = HW + DW;
	localparam int KLW   = FRAC + 1 + DW;
	localparam int SUMW  = KHW + 2;

	function automatic logic [DW-1:0] sat_fn(input logic signed [SUMW-1:0] v);
		logic [DW-1:0] r;
		if (v[SUMW-1:DW-1] == {(SUMW-DW+1){v[SUMW-1]}}) r = v[DW-1:0];
		else if (v[SUMW-1]) r = {1'b1, {(DW-1){1'b0}}};
		else r = {1'b0, {(DW-1){1'b1}}};
		return r;
	endfunction

	function automatic logic [DW-1:0] neg_sat(input logic [DW-1:0] x);
		logic [DW-1:0] r;
		if (x == {1'b1, {(DW-1){1'b0}}}) r = {1'b0, {(DW-1){1'b1}}};
		else r = -x;
		return r;
	endfunction

	logic [PW-1:0] a_mem [DEPTH];
	logic [PW-1:0] b_mem [DEPTH];
	logic [PW-1:0] c_mem [DEPTH];
	logic [PW-1:0] r_mem [DEPTH];

	cmca_pkg::bk_state_t state_q, state_d;

	logic [NW-1:0] n_w;
	logic [DW-1:0] k_w;
	logic          mirror_w;
	logic          anti_w;
	logic [OW-1:0] i_q, j_q, er_q, ec_q;
	logic [SW-1:0] s_q;
	logic [OW-1:0] t_w;
	logic          last_step_w, entry_last_w, emit_last_w, swap_w;
	logic [MW-1:0] mi_w, mt_w, mr_w, mc_w;
	logic [IW-1:0] addr0_w, addr1_w, e_addr_w, emit_addr_w;

	logic          pop_last_w;
	logic [IW-1:0] pop_idx_w;
	logic          pop_w, issue_w, scale_w, write_w, emit_go_w, clear_d_w;

	logic [PW-1:0] a0_s1, a1_s1, b0_s1, b1_s1;
	logic          v_s1, ph_s1;
	logic signed [FW-1:0] p_rr_s2, p_ii_s2, p_ri_s2, p_ir_s2;
	logic          v_s2, ph_s2;
	logic signed [DDW-1:0] d_re_q, d_im_q;
	logic [PW-1:0] c_rd_q;
	logic signed [KHW-1:0] kh_re_q, kh_im_q;
	logic signed [KLW-1:0] kl_re_q, kl_im_q;

	logic [PW-1:0] r_rd_q;
	logic          rdv_q, swap_s1, last_s1;
	logic          ov_q;
	logic [DW-1:0] res_re_q, res_im_q;
	logic          last_q;

	// Control decode
	always_comb begin
		n_w      = NW'(cmca_pkg::clamp_order(cfg_i.order, MAX_ORDER));
		k_w      = cfg_i.coef[DW-1:0];
		anti_w   = cfg_i.mode == cmca_pkg::MODE_ANTI;
		mirror_w = anti_w || (cfg_i.mode == cmca_pkg::MODE_HERM);
		t_w      = s_q[SW-1:1];
		last_step_w  = int'(s_q) == 2 * int'(n_w) - 1;
		entry_last_w = (int'(i_q) == int'(n_w) - 1) && (int'(j_q) == int'(n_w) - 1);
		emit_last_w  = (int'(er_q) == int'(n_w) - 1) && (int'(ec_q) == int'(n_w) - 1);
		swap_w       = mirror_w && (ec_q < er_q);
		mi_w = MW'(i_q) * MW'(n_w);
		mt_w = MW'(t_w) * MW'(n_w);
		mr_w = MW'(er_q) * MW'(n_w);
		mc_w = MW'(ec_q) * MW'(n_w);
		addr0_w     = IW'(mi_w + MW'(t_w));
		addr1_w     = IW'(mt_w + MW'(j_q));
		e_addr_w    = IW'(mi_w + MW'(j_q));
		emit_addr_w = swap_w ? IW'(mc_w + MW'(er_q)) : IW'(mr_w + MW'(ec_q));
		pop_last_w  = pop_data[QW-1];
		pop_idx_w   = pop_data[QW-2 -: IW];
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			cmca_pkg::BK_LOAD:  if (pop_valid && pop_last_w) state_d = cmca_pkg::BK_ISSUE;
			cmca_pkg::BK_ISSUE: if (last_step_w) state_d = cmca_pkg::BK_DRAIN;
			cmca_pkg::BK_DRAIN: if (!v_s1 && !v_s2) state_d = cmca_pkg::BK_SCALE;
			cmca_pkg::BK_SCALE: state_d = cmca_pkg::BK_WRITE;
			cmca_pkg::BK_WRITE: state_d = entry_last_w ? cmca_pkg::BK_EMIT : cmca_pkg::BK_ISSUE;
			cmca_pkg::BK_EMIT:  if (emit_go_w && emit_last_w) state_d = cmca_pkg::BK_LOAD;
			default:            state_d = cmca_pkg::BK_LOAD;
		endcase
	end

	// State outputs
	always_comb begin
		pop_ready = state_q == cmca_pkg::BK_LOAD;
		issue_w   = state_q == cmca_pkg::BK_ISSUE;
		scale_w   = state_q == cmca_pkg::BK_SCALE;
		write_w   = state_q == cmca_pkg::BK_WRITE;
		emit_go_w = (state_q == cmca_pkg::BK_EMIT) && !rdv_q && !ov_q;
	end

	assign pop_w     = pop_valid && pop_ready;
	assign clear_d_w = (pop_w && pop_last_w) || write_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cmca_pkg::BK_LOAD;
			i_q     <= '0;
			j_q     <= '0;
			s_q     <= '0;
			er_q    <= '0;
			ec_q    <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			rdv_q   <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			v_s1    <= issue_w;
			v_s2    <= v_s1;
			if (pop_w && pop_last_w) begin
				i_q <= '0;
				j_q <= '0;
				s_q <= '0;
			end
			if (issue_w) s_q <= s_q + SW'(1);
			if (write_w) begin
				s_q <= '0;
				if (int'(j_q) == int'(n_w) - 1) begin
					i_q <= i_q + OW'(1);
					j_q <= mirror_w ? i_q + OW'(1) : '0;
				end else begin
					j_q <= j_q + OW'(1);
				end
				er_q <= '0;
				ec_q <= '0;
			end
			if (emit_go_w) begin
				if (int'(ec_q) == int'(n_w) - 1) begin
					ec_q <= '0;
					er_q <= er_q + OW'(1);
				end else begin
					ec_q <= ec_q + OW'(1);
				end
			end
			rdv_q <= emit_go_w;
			if (rdv_q) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
		end
	end

	// Stores and registered reads
	always_ff @(posedge clk) begin
		if (pop_w) begin
			a_mem[pop_idx_w] <= pop_data[6*DW-1 -: PW];
			b_mem[pop_idx_w] <= pop_data[4*DW-1 -: PW];
			c_mem[pop_idx_w] <= pop_data[2*DW-1 -: PW];
		end
		a0_s1  <= a_mem[addr0_w];
		a1_s1  <= a_mem[addr1_w];
		b0_s1  <= b_mem[addr0_w];
		b1_s1  <= b_mem[addr1_w];
		c_rd_q <= c_mem[e_addr_w];
		r_rd_q <= r_mem[emit_addr_w];
		ph_s1  <= s_q[0];
	end

	// Complex multiply, floored products
	logic [PW-1:0] x_w, y_w;
	logic signed [DW-1:0] xr_w, xi_w, yr_w, yi_w;
	logic signed [PW-1:0] m_rr_w, m_ii_w, m_ri_w, m_ir_w;

	always_comb begin
		x_w    = ph_s1 ? b0_s1 : a0_s1;
		y_w    = ph_s1 ? a1_s1 : b1_s1;
		xr_w   = x_w[PW-1:DW];
		xi_w   = x_w[DW-1:0];
		yr_w   = y_w[PW-1:DW];
		yi_w   = y_w[DW-1:0];
		m_rr_w = xr_w * yr_w;
		m_ii_w = xi_w * yi_w;
		m_ri_w = xr_w * yi_w;
		m_ir_w = xi_w * yr_w;
	end

	always_ff @(posedge clk) begin
		p_rr_s2 <= m_rr_w[PW-1:FRAC];
		p_ii_s2 <= m_ii_w[PW-1:FRAC];
		p_ri_s2 <= m_ri_w[PW-1:FRAC];
		p_ir_s2 <= m_ir_w[PW-1:FRAC];
		ph_s2   <= ph_s1;
	end

	// Accumulate commutator entry
	logic [FW:0]    t_re_w, t_im_w;
	logic [DDW-1:0] te_re_w, te_im_w;

	always_comb begin
		t_re_w  = {p_rr_s2[FW-1], p_rr_s2} - {p_ii_s2[FW-1], p_ii_s2};
		t_im_w  = {p_ri_s2[FW-1], p_ri_s2} + {p_ir_s2[FW-1], p_ir_s2};
		te_re_w = {{(DDW-FW-1){t_re_w[FW]}}, t_re_w};
		te_im_w = {{(DDW-FW-1){t_im_w[FW]}}, t_im_w};
	end

	always_ff @(posedge clk) begin
		if (clear_d_w) begin
			d_re_q <= '0;
			d_im_q <= '0;
		end else if (v_s2) begin
			d_re_q <= ph_s2 ? d_re_q - te_re_w : d_re_q + te_re_w;
			d_im_q <= ph_s2 ? d_im_q - te_im_w : d_im_q + te_im_w;
		end
	end

	// Scale by coefficient, split to keep multipliers narrow
	always_ff @(posedge clk) begin
		if (scale_w) begin
			kh_re_q <= $signed(d_re_q[DDW-1:FRAC]) * $signed(k_w);
			kh_im_q <= $signed(d_im_q[DDW-1:FRAC]) * $signed(k_w);
			kl_re_q <= $signed({1'b0, d_re_q[FRAC-1:0]}) * $signed(k_w);
			kl_im_q <= $signed({1'b0, d_im_q[FRAC-1:0]}) * $signed(k_w);
		end
	end

	logic signed [SUMW-1:0] sum_re_w, sum_im_w;
	logic [DW-1:0]          wr_re_w, wr_im_w;

	always_comb begin
		sum_re_w = SUMW'($signed(c_rd_q[PW-1:DW])) + SUMW'(kh_re_q)
			+ SUMW'($signed(kl_re_q[KLW-1:FRAC]));
		sum_im_w = SUMW'($signed(c_rd_q[DW-1:0])) + SUMW'(kh_im_q)
			+ SUMW'($signed(kl_im_q[KLW-1:FRAC]));
		wr_re_w  = (anti_w && (i_q == j_q)) ? c_rd_q[PW-1:DW] : sat_fn(sum_re_w);
		wr_im_w  = sat_fn(sum_im_w);
	end

	always_ff @(posedge clk) begin
		if (write_w) begin
			r_mem[e_addr_w] <= {wr_re_w, wr_im_w};
		end
		if (emit_go_w) begin
			swap_s1 <= swap_w;
			last_s1 <= emit_last_w;
		end
		if (rdv_q) begin
			last_q <= last_s1;
			if (swap_s1 && anti_w) begin
				res_re_q <= neg_sat(r_rd_q[PW-1:DW]);
				res_im_q <= r_rd_q[DW-1:0];
			end else if (swap_s1) begin
				res_re_q <= r_rd_q[PW-1:DW];
				res_im_q <= neg_sat(r_rd_q[DW-1:0]);
			end else begin
				res_re_q <= r_rd_q[PW-1:DW];
				res_im_q <= r_rd_q[DW-1:0];
			end
		end
	end

	assign out_valid    = ov_q;
	assign res_re       = res_re_q;
	assign res_im       = res_im_q;
	assign last_element = last_q;

endmodule

FILE: rtl/complex_matrix_commutator_accumulate.sv
// Top level of the complex matrix commutator accumulator.
// Ties the front end, item queue and back end to the channel interfaces.
// Depends on cmca_pkg, cmca_if, cmca_front, cmca_queue, cmca_back.
//
// Loads A, B and the prior C one complex element per item, row-major, and on the
// n*n-th item emits C + k*(AB - BA) as n*n result items with last_element on the
// final one; mirror modes compute only the upper triangle and diagonal and fill
// the lower triangle. Items are taken one per cycle while the queue has room.
// Every computed entry (n*n in full mode, n*(n+1)/2 in mirror modes) goes
// through the single shared complex multiplier, one complex product per cycle.
// Results are read through the one read port of the result memory, each only
// once the previous one has left the result register, which decouples the
// output side. The four-deep queue holds items while a matrix is computed.
module complex_matrix_commutator_accumulate #(
	parameter int MAX_ORDER  = cmca_pkg::MAX_ORDER_DEF,
	parameter int DATA_WIDTH = cmca_pkg::DATA_WIDTH_DEF
) (
	input logic        clk,
	input logic        arst_n,
	cmca_cfg_if.sink   cfg,
	cmca_in_if.sink    data_in,
	cmca_out_if.source data_out
);
	localparam int IW = $clog2(MAX_ORDER * MAX_ORDER);
	localparam int QW = 6 * DATA_WIDTH + IW + 1;

	cmca_pkg::cfg_t cfg_w;
	logic           push_valid, push_ready, pop_valid, pop_ready;
	logic [QW-1:0]  push_data, pop_data;

	cmca_front #(
		.MAX_ORDER (MAX_ORDER),
		.DATA_WIDTH(DATA_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg.valid),
		.cfg_ready (cfg.ready),
		.cfg_index (cfg.index),
		.cfg_data  (cfg.data),
		.in_valid  (data_in.valid),
		.in_ready  (data_in.ready),
		.a_re      (data_in.a_re),
		.a_im      (data_in.a_im),
		.b_re      (data_in.b_re),
		.b_im      (data_in.b_im),
		.acc_re    (data_in.acc_re),
		.acc_im    (data_in.acc_im),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_data),
		.cfg_o     (cfg_w)
	);

	cmca_queue #(
		.WIDTH(QW),
		.DEPTH(cmca_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_data),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data)
	);

	cmca_back #(
		.MAX_ORDER (MAX_ORDER),
		.DATA_WIDTH(DATA_WIDTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.pop_valid   (pop_valid),
		.pop_ready   (pop_ready),
		.pop_data    (pop_data),
		.cfg_i       (cfg_w),
		.out_valid   (data_out.valid),
		.out_ready   (data_out.ready),
		.res_re      (data_out.res_re),
		.res_im      (data_out.res_im),
		.last_element(data_out.last_element)
	);

endmodule

FILE: rtl/cmca_checker.sv
// Port-level checker for the complex matrix commutator accumulator, bound to the top level.
// Depends on complex_matrix_commutator_accumulate and its interfaces.
module cmca_checker #(
	parameter int DATA_WIDTH = cmca_pkg::DATA_WIDTH_DEF
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  cfg_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [DATA_WIDTH-1:0] out_res_re,
	input logic [DATA_WIDTH-1:0] out_res_im,
	input logic                  out_last
);

	// stalled result item holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_res_re)
			&& $stable(out_res_im) && $stable(out_last))
		else $error("result item changed while stalled");

	// a matrix ends with a gap before the next one
	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_last |=> !out_valid)
		else $error("result item right after last element");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("config write stalled");

endmodule

bind complex_matrix_commutator_accumulate cmca_checker #(
	.DATA_WIDTH(DATA_WIDTH)
) u_cmca_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cfg_ready (cfg.ready),
	.out_valid (data_out.valid),
	.out_ready (data_out.ready),
	.out_res_re(data_out.res_re),
	.out_res_im(data_out.res_im),
	.out_last  (data_out.last_element)
);

FILE: bench/cmca_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the complex matrix commutator accumulator: watches the config,
// input and result channels, predicts every result matrix and compares item by item.
// Depends on cmca_pkg and cmca_if.
module cmca_scoreboard (
	input  logic clk,
	input  logic arst_n,
	cmca_cfg_if  cfg,
	cmca_in_if   din,
	cmca_out_if  dout,
	output int   fails,
	output int   pending
);

	typedef struct {
		logic signed [31:0] re;
		logic signed [31:0] im;
		logic               last;
	} elem_t;

	elem_t       result_fifo[$];
	logic [1:0]  mode;
	logic [31:0] coef;
	logic [3:0]  order;
	int          fill;
	longint      ar[64], ai[64], br[64], bi[64], cr[64], ci[64];

	initial fails = 0;
	initial pending = 0;

	function automatic longint qmul(longint x, longint y);
		return (x * y) >>> cmca_pkg::FRAC_BITS;
	endfunction

	function automatic longint apply_coef(longint d, longint k);
		longint dh, dl;
		dh = d >>> cmca_pkg::FRAC_BITS;
		dl = d - (dh <<< cmca_pkg::FRAC_BITS);
		return dh * k + ((dl * k) >>> cmca_pkg::FRAC_BITS);
	endfunction

	function automatic longint sat32(longint x);
		if (x > 64'sd2147483647) return 64'sd2147483647;
		if (x < -64'sd2147483648) return -64'sd2147483648;
		return x;
	endfunction

	function automatic int eff_order();
		int n;
		n = int'(order);
		if (n < 1) n = 1;
		if (n > cmca_pkg::MAX_ORDER_DEF) n = cmca_pkg::MAX_ORDER_DEF;
		return n;
	endfunction

	function automatic void finish_matrix(int n);
		longint rr[64], ri[64];
		longint dre, dim, k, ore, oim;
		int     e, ia, ib, ic, id;
		bit     mirror;
		elem_t  x;
		k = longint'($signed(coef));
		mirror = (mode == cmca_pkg::MODE_ANTI) || (mode == cmca_pkg::MODE_HERM);
		for (int i = 0; i < n; i++) begin
			for (int j = 0; j < n; j++) begin
				if (mirror && j < i) continue;
				e = i * n + j;
				dre = 0;
				dim = 0;
				for (int t = 0; t < n; t++) begin
					ia = i * n + t;
					ib = t * n + j;
					dre += qmul(ar[ia], br[ib]) - qmul(ai[ia], bi[ib])
						- qmul(br[ia], ar[ib]) + qmul(bi[ia], ai[ib]);
					dim += qmul(ar[ia], bi[ib]) + qmul(ai[ia], br[ib])
						- qmul(br[ia], ai[ib]) - qmul(bi[ia], ar[ib]);
				end
				ore = sat32(cr[e] + apply_coef(dre, k));
				oim = sat32(ci[e] + apply_coef(dim, k));
				if (mode == cmca_pkg::MODE_ANTI && i == j) ore = cr[e];
				rr[e] = ore;
				ri[e] = oim;
				if (mirror && j > i) begin
					if (mode == cmca_pkg::MODE_ANTI) begin
						rr[j * n + i] = sat32(-ore);
						ri[j * n + i] = oim;
					end else begin
						rr[j * n + i] = ore;
						ri[j * n + i] = sat32(-oim);
					end
				end
			end
		end
		for (int m = 0; m < n * n; m++) begin
			x.re = rr[m][31:0];
			x.im = ri[m][31:0];
			x.last = (m == n * n - 1);
			result_fifo.push_back(x);
		end
	endfunction

	task automatic report(string what, longint got, longint want);
		$display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
		fails++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		elem_t w;
		int    n;
		if (!arst_n) begin
			mode = cmca_pkg::MODE_FULL;
			coef = cmca_pkg::COEF_RESET;
			order = cmca_pkg::ORDER_RESET;
			fill = 0;
			result_fifo.delete();
		end else begin
			if (dout.valid && dout.ready) begin
				if (result_fifo.size() == 0) begin
					report("unexpected result item", dout.res_re, 0);
				end else begin
					w = result_fifo.pop_front();
					if (dout.res_re !== w.re) report("res_re", dout.res_re, w.re);
					if (dout.res_im !== w.im) report("res_im", dout.res_im, w.im);
					if (dout.last_element !== w.last)
						report("last_element", dout.last_element, w.last);
				end
			end
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					cmca_pkg::REG_MODE:  mode = cfg.data[1:0];
					cmca_pkg::REG_COEF:  coef = cfg.data;
					cmca_pkg::REG_ORDER: order = cfg.data[3:0];
					default: ;
				endcase
			end
			if (din.valid && din.ready) begin
				ar[fill] = longint'(din.a_re);
				ai[fill] = longint'(din.a_im);
				br[fill] = longint'(din.b_re);
				bi[fill] = longint'(din.b_im);
				cr[fill] = longint'(din.acc_re);
				ci[fill] = longint'(din.acc_im);
				fill++;
				n = eff_order();
				if (fill >= n * n) begin
					fill = 0;
					finish_matrix(n);
				end
			end
		end
		pending = result_fifo.size();
	end

endmodule

FILE: bench/complex_matrix_commutator_accumulate_tb.sv
`timescale 1ns / 1ps
// Top of the bench: clock, reset, config phases, matrix stimulus and result back-pressure.
// Depends on cmca_pkg, cmca_if, the block and cmca_scoreboard.
module complex_matrix_commutator_accumulate_tb;

	localparam logic [1:0] MODE_SPARE = 2'd3;
	localparam int         LIMIT      = 400000;
	localparam int         HOLD_LEN   = 400;

	logic clk;
	logic arst_n;
	int   fails, pending, cycles, sent, big_runs;
	bit   hold_go;

	cmca_cfg_if          cfg_ch ();
	cmca_in_if #(32)     din ();
	cmca_out_if #(32)    dout ();

	complex_matrix_commutator_accumulate dut (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_ch), .data_in(din), .data_out(dout)
	);

	cmca_scoreboard chk (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_ch), .din(din), .dout(dout),
		.fails(fails), .pending(pending)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycles = 0;
		hold_go = 0;
		arst_n = 0;
		cfg_ch.valid = 0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		din.valid = 0;
		{din.a_re, din.a_im, din.b_re, din.b_im, din.acc_re, din.acc_im} = '0;
		dout.ready = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	function automatic logic [31:0] pick_word(bit edgy);
		int c;
		c = $urandom_range(0, 9);
		if (edgy || c < 3) begin
			case ($urandom_range(0, 5))
				0: return 32'h8000_0000;
				1: return 32'h7FFF_FFFF;
				2: return 32'h0000_0000;
				3: return 32'h0100_0000;
				4: return 32'hFF00_0000;
				default: return 32'hFFFF_FFFF;
			endcase
		end
		if (c < 7) return 32'($signed($urandom_range(0, 32'h07FF_FFFF)) - 32'sh0400_0000);
		return $urandom;
	endfunction

	task automatic write_reg(logic [cmca_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
		cfg_ch.valid <= 1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.valid <= 0;
		@(posedge clk);
	endtask

	task automatic send_item(bit edgy);
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			din.valid <= 0;
			repeat (gap) @(posedge clk);
		end
		din.valid <= 1;
		din.a_re <= pick_word(edgy);
		din.a_im <= pick_word(edgy);
		din.b_re <= pick_word(edgy);
		din.b_im <= pick_word(edgy);
		din.acc_re <= pick_word(edgy);
		din.acc_im <= pick_word(edgy);
		@(posedge clk);
		while (!din.ready) @(posedge clk);
		sent++;
	endtask

	task automatic run_phase(logic [1:0] m, logic [31:0] k, logic [3:0] ord, int mats,
			bit edgy, bit hold);
		int n;
		write_reg(cmca_pkg::REG_MODE, {30'd0, m});
		write_reg(cmca_pkg::REG_COEF, k);
		write_reg(cmca_pkg::REG_ORDER, {28'd0, ord});
		n = (ord < 1) ? 1 :
			((ord > cmca_pkg::MAX_ORDER_DEF) ? cmca_pkg::MAX_ORDER_DEF : int'(ord));
		if (hold) hold_go = 1;
		for (int i = 0; i < mats * n * n; i++) send_item(edgy);
		din.valid <= 0;
		// let the scoreboard see the last item before polling its count
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	// result side back-pressure, with one long hold-off on request
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
			if (hold_go) begin
				hold_go = 0;
				dout.ready <= 0;
				repeat (HOLD_LEN) @(posedge clk);
			end else if (gap > 0) begin
				dout.ready <= 0;
				repeat (gap) @(posedge clk);
			end
			dout.ready <= 1;
			@(posedge clk);
			while (!dout.valid) @(posedge clk);
		end
	end

	initial begin
		logic [1:0]  m;
		logic [31:0] k;
		logic [3:0]  ord;
		sent = 0;
		big_runs = 0;
		@(posedge arst_n);
		repeat (3) @(posedge clk);
		run_phase(cmca_pkg::MODE_FULL, 32'h7FFF_FFFF, 4'd2, 1, 1, 0);
		run_phase(cmca_pkg::MODE_ANTI, 32'h8000_0000, 4'd1, 1, 1, 0);
		run_phase(cmca_pkg::MODE_HERM, cmca_pkg::COEF_RESET, 4'd3, 1, 1, 0);
		run_phase(MODE_SPARE, 32'h0000_0000, 4'd0, 1, 1, 0);
		run_phase(cmca_pkg::MODE_ANTI, 32'hFF00_0000, 4'd2, 1, 1, 0);
		run_phase(cmca_pkg::MODE_FULL, cmca_pkg::COEF_RESET, 4'd2, 6, 0, 1);
		while (sent < 360) begin
			m = 2'($urandom_range(0, 3));
			case ($urandom_range(0, 5))
				0: k = 32'h8000_0000;
				1: k = 32'h7FFF_FFFF;
				2: k = cmca_pkg::COEF_RESET;
				3: k = 32'($signed($urandom_range(0, 32'h03FF_FFFF)) - 32'sh0200_0000);
				default: k = $urandom;
			endcase
			if (big_runs < 3 && $urandom_range(0, 7) == 0) begin
				big_runs++;
				ord = (big_runs == 2) ? 4'd15 : 4'd8;
				run_phase(m, k, ord, 1, 0, 0);
			end else begin
				ord = 4'($urandom_range(0, 4));
				run_phase(m, k, ord, $urandom_range(1, 3), 0, 0);
			end
		end
		while (pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (fails == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

FILE: files.f
rtl/cmca_pkg.sv
rtl/cmca_if.sv
rtl/cmca_front.sv
rtl/cmca_queue.sv
rtl/cmca_back.sv
rtl/complex_matrix_commutator_accumulate.sv
rtl/cmca_checker.sv
bench/cmca_checker.sv
bench/complex_matrix_commutator_accumulate_tb.sv
